>>> rtl/core/url_part_locator_macros.svh
// Assertion helpers used by the checker file ulp_checker.sv
`ifndef URL_PART_LOCATOR_MACROS_SVH
`define URL_PART_LOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ULP_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ULP_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ulp_pkg.sv
`timescale 1ns / 1ps
package ulp_pkg;

  // Default for the longest URL that is still located
  localparam int MAX_LEN_DEF = 4096;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int PART_W  = 4;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;

  // Config port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_URL_PART = 1'b0;

  // Part selector codes
  localparam logic [PART_W-1:0] PART_AUTHORITY = 4'd0;
  localparam logic [PART_W-1:0] PART_FILE      = 4'd1;
  localparam logic [PART_W-1:0] PART_HOST      = 4'd2;
  localparam logic [PART_W-1:0] PART_PATH      = 4'd3;
  localparam logic [PART_W-1:0] PART_PROTOCOL  = 4'd4;
  localparam logic [PART_W-1:0] PART_QUERY     = 4'd5;
  localparam logic [PART_W-1:0] PART_REF       = 4'd6;
  localparam logic [PART_W-1:0] PART_USERINFO  = 4'd7;
  localparam logic [PART_W-1:0] PART_PORT      = 4'd8;
  localparam logic [PART_W-1:0] PART_INVALID   = 4'd9;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_QUEST  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_AT     = 8'h40;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;

  // Scheme separator matcher
  typedef enum logic [2:0] {
    SCH_IDLE  = 3'b001,
    SCH_COLON = 3'b010,
    SCH_SLASH = 3'b100
  } scheme_st_t;

endpackage

>>> rtl/core/ulp_regs.sv
`timescale 1ns / 1ps
module ulp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ulp_pkg::ADDR_W-1:0]    paddr,
  input  logic [ulp_pkg::DATA_W-1:0]    pwdata,
  output logic [ulp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output logic [ulp_pkg::PART_W-1:0]    url_part
);

  logic sel_part;

  assign sel_part = (paddr[ulp_pkg::ADDR_W-1:2] == ulp_pkg::REG_URL_PART);
  assign pready   = 1'b1;

  // Part selector register
  always_ff @(posedge clk) begin
    if (rst) begin
      url_part <= ulp_pkg::PART_INVALID;
    end else if (psel && penable && pwrite && pready && sel_part) begin
      url_part <= pwdata[ulp_pkg::PART_W-1:0];
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    if (sel_part) begin
      prdata = ulp_pkg::DATA_W'(url_part);
    end
  end

endmodule

>>> rtl/core/ulp_tracker.sv
`timescale 1ns / 1ps
module ulp_tracker #(
  parameter int MAX_LEN = ulp_pkg::MAX_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [ulp_pkg::BYTE_W-1:0]  url_byte,
  input  logic                        is_last,
  output logic                        snap_valid,
  input  logic                        snap_ready,
  output logic                        snap_too_long,
  output logic [$clog2(MAX_LEN+1)-1:0] snap_first_ns,
  output logic [$clog2(MAX_LEN+1)-1:0] snap_last_ns,
  output logic [$clog2(MAX_LEN+1)-1:0] snap_sep,
  output logic [$clog2(MAX_LEN+1)-1:0] snap_slash,
  output logic [$clog2(MAX_LEN+1)-1:0] snap_quest,
  output logic [$clog2(MAX_LEN+1)-1:0] snap_hash,
  output logic [$clog2(MAX_LEN+1)-1:0] snap_at,
  output logic                        snap_bracketed,
  output logic [$clog2(MAX_LEN+1)-1:0] snap_close,
  output logic                        snap_then_colon,
  output logic [$clog2(MAX_LEN+1)-1:0] snap_colon
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam logic [PW-1:0] NONE  = '1;
  localparam logic [PW-1:0] LIMIT = PW'(MAX_LEN);

  ulp_pkg::scheme_st_t scheme_st, scheme_st_next;
  logic [PW-1:0] pos, pos_next;
  logic          too_long, too_long_next;
  logic [PW-1:0] first_ns, first_ns_next;
  logic [PW-1:0] last_ns, last_ns_next;
  logic [PW-1:0] sep, sep_next;
  logic [PW-1:0] slash, slash_next;
  logic [PW-1:0] quest, quest_next;
  logic [PW-1:0] hash, hash_next;
  logic [PW-1:0] at_pos, at_pos_next;
  logic          bracketed, bracketed_next;
  logic [PW-1:0] close_pos, close_pos_next;
  logic          then_colon, then_colon_next;
  logic [PW-1:0] host_colon, host_colon_next;
  logic [PW-1:0] host_begin;
  logic          auth_open;
  logic          accept;
  logic          is_delim;

  assign accept     = item_valid && item_ready;
  assign item_ready = !snap_valid || snap_ready;
  assign auth_open  = (slash == NONE) && (quest == NONE) && (hash == NONE);
  assign host_begin = (at_pos == NONE) ? sep + PW'(3) : at_pos + PW'(1);
  assign is_delim   = (url_byte == ulp_pkg::CH_SLASH) || (url_byte == ulp_pkg::CH_QUEST) ||
                      (url_byte == ulp_pkg::CH_HASH);

  // Per-byte update of the position marks
  always_comb begin
    pos_next        = pos;
    too_long_next   = too_long;
    scheme_st_next  = scheme_st;
    first_ns_next   = first_ns;
    last_ns_next    = last_ns;
    sep_next        = sep;
    slash_next      = slash;
    quest_next      = quest;
    hash_next       = hash;
    at_pos_next     = at_pos;
    bracketed_next  = bracketed;
    close_pos_next  = close_pos;
    then_colon_next = then_colon;
    host_colon_next = host_colon;
    if (pos == LIMIT) begin
      // past the length limit: bytes only flag the overflow
      too_long_next = 1'b1;
    end else begin
      pos_next = pos + PW'(1);
      if (url_byte != ulp_pkg::CH_SPACE) begin
        if (first_ns == NONE) first_ns_next = pos;
        last_ns_next = pos;
      end
      if (sep == NONE) begin
        // hunting for "://"
        if (url_byte == ulp_pkg::CH_COLON) begin
          scheme_st_next = ulp_pkg::SCH_COLON;
        end else if (url_byte == ulp_pkg::CH_SLASH && scheme_st == ulp_pkg::SCH_COLON) begin
          scheme_st_next = ulp_pkg::SCH_SLASH;
        end else if (url_byte == ulp_pkg::CH_SLASH && scheme_st == ulp_pkg::SCH_SLASH) begin
          sep_next       = pos - PW'(2);
          scheme_st_next = ulp_pkg::SCH_IDLE;
        end else begin
          scheme_st_next = ulp_pkg::SCH_IDLE;
        end
      end else if (is_delim) begin
        if (url_byte == ulp_pkg::CH_SLASH && slash == NONE) slash_next = pos;
        if (url_byte == ulp_pkg::CH_QUEST && quest == NONE) quest_next = pos;
        if (url_byte == ulp_pkg::CH_HASH && hash == NONE) hash_next = pos;
      end else if (auth_open) begin
        if (url_byte == ulp_pkg::CH_AT) begin
          // new userinfo end: host tracking restarts
          at_pos_next     = pos;
          bracketed_next  = 1'b0;
          close_pos_next  = NONE;
          then_colon_next = 1'b0;
          host_colon_next = NONE;
        end else if (pos == host_begin && url_byte == ulp_pkg::CH_LBRACK) begin
          bracketed_next = 1'b1;
        end else if (bracketed) begin
          if (close_pos == NONE) begin
            if (url_byte == ulp_pkg::CH_RBRACK) close_pos_next = pos;
          end else if (close_pos + PW'(1) == pos && url_byte == ulp_pkg::CH_COLON) begin
            then_colon_next = 1'b1;
          end
        end else if (url_byte == ulp_pkg::CH_COLON && host_colon == NONE) begin
          host_colon_next = pos;
        end
      end
    end
  end

  // Stream state: cleared at reset and after each last byte
  always_ff @(posedge clk) begin
    if (rst || (accept && is_last)) begin
      pos        <= '0;
      too_long   <= 1'b0;
      scheme_st  <= ulp_pkg::SCH_IDLE;
      first_ns   <= NONE;
      last_ns    <= NONE;
      sep        <= NONE;
      slash      <= NONE;
      quest      <= NONE;
      hash       <= NONE;
      at_pos     <= NONE;
      bracketed  <= 1'b0;
      close_pos  <= NONE;
      then_colon <= 1'b0;
      host_colon <= NONE;
    end else if (accept) begin
      pos        <= pos_next;
      too_long   <= too_long_next;
      scheme_st  <= scheme_st_next;
      first_ns   <= first_ns_next;
      last_ns    <= last_ns_next;
      sep        <= sep_next;
      slash      <= slash_next;
      quest      <= quest_next;
      hash       <= hash_next;
      at_pos     <= at_pos_next;
      bracketed  <= bracketed_next;
      close_pos  <= close_pos_next;
      then_colon <= then_colon_next;
      host_colon <= host_colon_next;
    end
  end

  // Final marks of a finished URL
  always_ff @(posedge clk) begin
    if (accept && is_last) begin
      snap_too_long   <= too_long_next;
      snap_first_ns   <= first_ns_next;
      snap_last_ns    <= last_ns_next;
      snap_sep        <= sep_next;
      snap_slash      <= slash_next;
      snap_quest      <= quest_next;
      snap_hash       <= hash_next;
      snap_at         <= at_pos_next;
      snap_bracketed  <= bracketed_next;
      snap_close      <= close_pos_next;
      snap_then_colon <= then_colon_next;
      snap_colon      <= host_colon_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && is_last) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/ulp_resolver.sv
`timescale 1ns / 1ps
module ulp_resolver #(
  parameter int MAX_LEN = ulp_pkg::MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ulp_pkg::PART_W-1:0]   url_part,
  input  logic                         snap_valid,
  output logic                         snap_ready,
  input  logic                         snap_too_long,
  input  logic [$clog2(MAX_LEN+1)-1:0] snap_first_ns,
  input  logic [$clog2(MAX_LEN+1)-1:0] snap_last_ns,
  input  logic [$clog2(MAX_LEN+1)-1:0] snap_sep,
  input  logic [$clog2(MAX_LEN+1)-1:0] snap_slash,
  input  logic [$clog2(MAX_LEN+1)-1:0] snap_quest,
  input  logic [$clog2(MAX_LEN+1)-1:0] snap_hash,
  input  logic [$clog2(MAX_LEN+1)-1:0] snap_at,
  input  logic                         snap_bracketed,
  input  logic [$clog2(MAX_LEN+1)-1:0] snap_close,
  input  logic                         snap_then_colon,
  input  logic [$clog2(MAX_LEN+1)-1:0] snap_colon,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic                         found,
  output logic [ulp_pkg::START_W-1:0]  part_start,
  output logic [ulp_pkg::LEN_W-1:0]    part_length
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam logic [PW-1:0] NONE = '1;

  function automatic logic [PW-1:0] pmin(input logic [PW-1:0] x, input logic [PW-1:0] y);
    pmin = (x < y) ? x : y;
  endfunction

  logic          found_next;
  logic [PW-1:0] st_next, ln_next;
  logic [PW-1:0] e, p, a, h, endp, ps, a_raw;

  assign snap_ready = !result_valid || result_ready;

  // Common boundaries
  assign e     = snap_last_ns + PW'(1);
  assign p     = snap_sep + PW'(3);
  assign a_raw = pmin(pmin(snap_slash, snap_quest), snap_hash);
  assign a     = (a_raw == NONE) ? e : a_raw;
  assign h     = (snap_at == NONE) ? p : snap_at + PW'(1);

  // Pick start and length of the selected part
  always_comb begin
    found_next = 1'b0;
    st_next    = '0;
    ln_next    = '0;
    endp       = '0;
    ps         = '0;
    if (!snap_too_long && snap_sep != NONE && snap_first_ns != NONE) begin
      case (url_part)
        ulp_pkg::PART_AUTHORITY: begin
          found_next = 1'b1;
          st_next    = p;
          ln_next    = a - p;
        end
        ulp_pkg::PART_FILE, ulp_pkg::PART_PATH: begin
          found_next = 1'b1;
          // empty when no slash or a query/fragment comes first
          if (snap_slash != NONE && !(snap_quest < snap_slash) &&
              !(snap_hash < snap_slash)) begin
            endp = (url_part == ulp_pkg::PART_FILE) ? snap_hash :
                   pmin(snap_quest, snap_hash);
            if (endp == NONE) endp = e;
            st_next = snap_slash;
            ln_next = endp - snap_slash;
          end
        end
        ulp_pkg::PART_HOST: begin
          found_next = 1'b1;
          if (snap_bracketed) begin
            endp = (snap_close != NONE) ? snap_close + PW'(1) : a;
          end else begin
            endp = (snap_colon != NONE) ? snap_colon : a;
          end
          st_next = h;
          ln_next = endp - h;
        end
        ulp_pkg::PART_PROTOCOL: begin
          found_next = 1'b1;
          st_next    = snap_first_ns;
          ln_next    = snap_sep - snap_first_ns;
        end
        ulp_pkg::PART_QUERY: begin
          if (snap_quest != NONE && !(snap_hash < snap_quest)) begin
            found_next = 1'b1;
            endp       = (snap_hash != NONE) ? snap_hash : e;
            st_next    = snap_quest + PW'(1);
            ln_next    = endp - (snap_quest + PW'(1));
          end
        end
        ulp_pkg::PART_REF: begin
          if (snap_hash != NONE) begin
            found_next = 1'b1;
            st_next    = snap_hash + PW'(1);
            ln_next    = e - (snap_hash + PW'(1));
          end
        end
        ulp_pkg::PART_USERINFO: begin
          if (snap_at != NONE) begin
            found_next = 1'b1;
            st_next    = p;
            ln_next    = snap_at - p;
          end
        end
        ulp_pkg::PART_PORT: begin
          if (snap_bracketed) begin
            ps = snap_close + PW'(2);
            if (snap_close != NONE && snap_then_colon) begin
              found_next = 1'b1;
              st_next    = ps;
              ln_next    = a - ps;
            end
          end else begin
            ps = snap_colon + PW'(1);
            if (snap_colon != NONE) begin
              found_next = 1'b1;
              st_next    = ps;
              ln_next    = a - ps;
            end
          end
        end
        default: begin
          found_next = 1'b0;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      found       <= found_next;
      part_start  <= ulp_pkg::START_W'(st_next);
      part_length <= ulp_pkg::LEN_W'(ln_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (snap_valid && snap_ready) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/url_part_locator.sv
`timescale 1ns / 1ps
// URL part locator: one URL byte per item, one result after the byte marked is_last.
// Throughput: one byte per cycle while item_ready is high; the position marks update once per accepted byte.
// The marks are snapshotted at the edge that takes the last byte; the result register loads
// from the snapshot when the resolver is free, and result_valid rises; bytes stall only while
// both the snapshot and a stalled result are held.
// Reset (rst, synchronous): clears the stream marks and handshakes, url_part returns to 9.
module url_part_locator #(
  parameter int MAX_LEN = ulp_pkg::MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ulp_pkg::ADDR_W-1:0]   paddr,
  input  logic [ulp_pkg::DATA_W-1:0]   pwdata,
  output logic [ulp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [ulp_pkg::BYTE_W-1:0]   url_byte,
  input  logic                         is_last,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic                         found,
  output logic [ulp_pkg::START_W-1:0]  part_start,
  output logic [ulp_pkg::LEN_W-1:0]    part_length
);

  localparam int PW = $clog2(MAX_LEN + 1);

  logic [ulp_pkg::PART_W-1:0] url_part;
  logic          snap_valid, snap_ready;
  logic          snap_too_long, snap_bracketed, snap_then_colon;
  logic [PW-1:0] snap_first_ns, snap_last_ns, snap_sep, snap_slash, snap_quest;
  logic [PW-1:0] snap_hash, snap_at, snap_close, snap_colon;

  ulp_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .url_part (url_part)
  );

  ulp_tracker #(.MAX_LEN(MAX_LEN)) u_tracker (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .url_byte        (url_byte),
    .is_last         (is_last),
    .snap_valid      (snap_valid),
    .snap_ready      (snap_ready),
    .snap_too_long   (snap_too_long),
    .snap_first_ns   (snap_first_ns),
    .snap_last_ns    (snap_last_ns),
    .snap_sep        (snap_sep),
    .snap_slash      (snap_slash),
    .snap_quest      (snap_quest),
    .snap_hash       (snap_hash),
    .snap_at         (snap_at),
    .snap_bracketed  (snap_bracketed),
    .snap_close      (snap_close),
    .snap_then_colon (snap_then_colon),
    .snap_colon      (snap_colon)
  );

  ulp_resolver #(.MAX_LEN(MAX_LEN)) u_resolver (
    .clk             (clk),
    .rst             (rst),
    .url_part        (url_part),
    .snap_valid      (snap_valid),
    .snap_ready      (snap_ready),
    .snap_too_long   (snap_too_long),
    .snap_first_ns   (snap_first_ns),
    .snap_last_ns    (snap_last_ns),
    .snap_sep        (snap_sep),
    .snap_slash      (snap_slash),
    .snap_quest      (snap_quest),
    .snap_hash       (snap_hash),
    .snap_at         (snap_at),
    .snap_bracketed  (snap_bracketed),
    .snap_close      (snap_close),
    .snap_then_colon (snap_then_colon),
    .snap_colon      (snap_colon),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .found           (found),
    .part_start      (part_start),
    .part_length     (part_length)
  );

endmodule

>>> rtl/core/ulp_checker.sv
`timescale 1ns / 1ps
`include "url_part_locator_macros.svh"
module ulp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_ready,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic                         found,
  input logic [ulp_pkg::START_W-1:0]  part_start,
  input logic [ulp_pkg::LEN_W-1:0]    part_length
);

  // A result just out of reset would be a stale item
  `ULP_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !result_valid, "result valid right after reset")

  // With no result held, the byte side can never be stalled
  `ULP_ASSERT_NOW(a_ready_free, clk, rst, !result_valid, item_ready, "item_ready low with empty output")

  // A missing part always reports zero start and length
  `ULP_ASSERT_NOW(a_notfound_zero, clk, rst, result_valid && !found,
                  (part_start == '0) && (part_length == '0), "nonzero fields on a missing part")

  // A stalled result holds
  `ULP_ASSERT_NEXT(a_hold, clk, rst, result_valid && !result_ready,
                   result_valid && $stable(found) && $stable(part_start) && $stable(part_length),
                   "stalled result changed")

endmodule

bind url_part_locator ulp_checker u_ulp_checker (.*);
